FILE: hdl/rtam_pkg.sv
`default_nettype none

package rtam_pkg;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // Status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_REPLACED  = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    // Used-entry count per node, 0..256
    localparam int CNT_W = 9;
    localparam int FANOUT_W = 8;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_INS_RD,
        S_INS_WR,
        S_RM_RD,
        S_RM_DEC,
        S_RM_UP
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/rtam_ram.sv
`default_nettype none

// Simple dual-port synchronous RAM, registered read
module rtam_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/radix_tree_address_size_map_core.sv
`default_nettype none

// Radix tree (fanout 256) mapping an address to a size. One request is handled
// at a time. The walk visits one level at a time, reading the entry memory and
// then checking the entry, and it stops at the first missing level. A lookup, a
// replacing insert or a miss has its result when the walk stops. An insert that
// adds a key then writes each new node's link and the leaf. A remove that hits
// clears the leaf and updates its node's count, then frees each non-root node
// whose count falls to zero and updates its parent's link and count. The next
// request can be taken in the same cycle as the result is offered, if that
// result is taken then. The walk is bound by the entry memory's single read
// port. Node use counts and the free-node stack live in two small memories.
// After reset the block runs a clearing pass over the entry memory before it
// takes its first request.
module radix_tree_address_size_map_core #(
    parameter int KEY_BYTES = 4,
    parameter int NODE_POOL = 64,
    parameter int SIZE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] address,
    input  wire logic [31:0] size_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic             found,
    output logic [31:0]      stored_size
);

    localparam int NODE_W = $clog2(NODE_POOL);
    localparam int EADDR_W = NODE_W + rtam_pkg::FANOUT_W;
    localparam int EDEPTH = NODE_POOL * 256;
    localparam int DATA_W = (SIZE_BITS > NODE_W) ? SIZE_BITS : NODE_W;
    localparam int ENT_W = DATA_W + 1;
    localparam int LV_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [LV_W-1:0] LV_LAST = LV_W'(KEY_BYTES - 1);

    rtam_pkg::state_t state_reg, state_next;
    logic [EADDR_W-1:0]   clr_reg, clr_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [31:0]          addr_reg, addr_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [NODE_W-1:0]    path_reg [KEY_BYTES];
    logic [NODE_W-1:0]    path_next [KEY_BYTES];
    logic [LV_W-1:0]      lv_reg, lv_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic                 fresh_reg, fresh_next;
    logic [NODE_W-1:0]    sp_reg, sp_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic                 found_reg, found_next;
    logic [31:0]          size_out_reg, size_out_next;

    // memory ports
    logic                 ent_we;
    logic [EADDR_W-1:0]   ent_waddr, ent_raddr;
    logic [ENT_W-1:0]     ent_wdata, ent_rdata;
    logic                 cnt_we;
    logic [NODE_W-1:0]    cnt_waddr, cnt_raddr;
    logic [rtam_pkg::CNT_W-1:0] cnt_wdata, cnt_rdata;
    logic                 stk_we;
    logic [NODE_W-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    // key bytes at the current level and the one above
    logic [63:0]          addr_ext;
    logic [7:0]           key_byte, key_byte_up;
    logic [LV_W-1:0]      lv_up;
    logic                 ent_valid, inner, present;
    logic [LV_W-1:0]      need;
    logic [rtam_pkg::CNT_W-1:0] cnt_cur, cnt_dec;
    logic                 accept;

    assign addr_ext    = 64'(addr_reg);
    assign lv_up       = lv_reg - LV_W'(1);
    assign key_byte    = addr_ext[{3'(lv_reg), 3'b000} +: 8];
    assign key_byte_up = addr_ext[{3'(lv_up), 3'b000} +: 8];
    assign ent_valid   = ent_rdata[ENT_W-1];
    assign inner       = (lv_reg != LV_LAST);
    assign present     = !inner && ent_valid;
    assign need        = LV_LAST - lv_reg;
    assign cnt_cur     = fresh_reg ? '0 : cnt_rdata;
    assign cnt_dec     = (cnt_rdata != '0) ? cnt_rdata - rtam_pkg::CNT_W'(1) : cnt_rdata;
    assign accept      = in_valid && in_ready;

    assign in_ready    = (state_reg == rtam_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign stored_size = size_out_reg;

    rtam_ram #(.DEPTH(EDEPTH), .WIDTH(ENT_W)) u_ent (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    rtam_ram #(.DEPTH(NODE_POOL), .WIDTH(rtam_pkg::CNT_W)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    rtam_ram #(.DEPTH(NODE_POOL), .WIDTH(NODE_W)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Next state and register updates
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        size_next      = size_reg;
        path_next      = path_reg;
        lv_next        = lv_reg;
        node_next      = node_reg;
        fresh_next     = fresh_reg;
        sp_next        = sp_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        size_out_next  = size_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rtam_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + EADDR_W'(1);
                if (clr_reg == EADDR_W'(EDEPTH - 1))
                begin
                    state_next = rtam_pkg::S_IDLE;
                end
            end
            rtam_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd;
                    addr_next    = address;
                    size_next    = SIZE_BITS'(64'(size_value));
                    path_next[0] = '0;
                    lv_next      = '0;
                    state_next   = rtam_pkg::S_WALK_RD;
                end
            end
            rtam_pkg::S_WALK_RD:
            begin
                state_next = rtam_pkg::S_WALK_CHK;
            end
            rtam_pkg::S_WALK_CHK:
            begin
                if (inner && ent_valid)
                begin
                    path_next[lv_reg + LV_W'(1)] = ent_rdata[NODE_W-1:0];
                    lv_next    = lv_reg + LV_W'(1);
                    state_next = rtam_pkg::S_WALK_RD;
                end
                else
                begin
                    state_next     = rtam_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = rtam_pkg::STS_NOT_FOUND;
                    found_next     = 1'b0;
                    size_out_next  = '0;
                    case (cmd_reg)
                        rtam_pkg::CMD_INSERT:
                        begin
                            if (present)
                            begin
                                status_next = rtam_pkg::STS_REPLACED;
                                found_next  = 1'b1;
                            end
                            else if (16'(need) > 16'(sp_reg))
                            begin
                                status_next = rtam_pkg::STS_FULL;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                node_next      = path_reg[lv_reg];
                                fresh_next     = 1'b0;
                                state_next     = rtam_pkg::S_INS_RD;
                            end
                        end
                        rtam_pkg::CMD_REMOVE:
                        begin
                            if (present)
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                state_next     = rtam_pkg::S_RM_RD;
                            end
                        end
                        rtam_pkg::CMD_LOOKUP:
                        begin
                            if (present)
                            begin
                                status_next   = rtam_pkg::STS_OK;
                                found_next    = 1'b1;
                                size_out_next = 32'(64'(ent_rdata[SIZE_BITS-1:0]));
                            end
                        end
                        default:
                        begin
                            status_next = rtam_pkg::STS_NOT_FOUND;
                        end
                    endcase
                end
            end
            rtam_pkg::S_INS_RD:
            begin
                state_next = rtam_pkg::S_INS_WR;
            end
            rtam_pkg::S_INS_WR:
            begin
                if (inner)
                begin
                    node_next  = stk_rdata;
                    fresh_next = 1'b1;
                    sp_next    = sp_reg - NODE_W'(1);
                    lv_next    = lv_reg + LV_W'(1);
                    state_next = rtam_pkg::S_INS_RD;
                end
                else
                begin
                    state_next     = rtam_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = rtam_pkg::STS_OK;
                    found_next     = 1'b0;
                    size_out_next  = '0;
                end
            end
            rtam_pkg::S_RM_RD:
            begin
                state_next = rtam_pkg::S_RM_DEC;
            end
            rtam_pkg::S_RM_DEC:
            begin
                if ((cnt_dec == '0) && (lv_reg != '0))
                begin
                    state_next = rtam_pkg::S_RM_UP;
                end
                else
                begin
                    state_next     = rtam_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = rtam_pkg::STS_OK;
                    found_next     = 1'b1;
                    size_out_next  = '0;
                end
            end
            rtam_pkg::S_RM_UP:
            begin
                sp_next    = sp_reg + NODE_W'(1);
                lv_next    = lv_up;
                state_next = rtam_pkg::S_RM_RD;
            end
            default:
            begin
                state_next = rtam_pkg::S_IDLE;
            end
        endcase
    end

    // Memory port control
    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = {path_reg[lv_reg], key_byte};
        ent_wdata = '0;
        ent_raddr = {path_reg[lv_reg], key_byte};
        cnt_we    = 1'b0;
        cnt_waddr = path_reg[lv_reg];
        cnt_wdata = cnt_dec;
        cnt_raddr = path_reg[lv_reg];
        stk_we    = 1'b0;
        stk_waddr = sp_reg;
        stk_wdata = path_reg[lv_reg];
        stk_raddr = sp_reg - NODE_W'(1);

        case (state_reg)
            rtam_pkg::S_CLEAR:
            begin
                ent_we    = 1'b1;
                ent_waddr = clr_reg;
                if (clr_reg < EADDR_W'(NODE_POOL))
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = clr_reg[NODE_W-1:0];
                    cnt_wdata = '0;
                    stk_we    = 1'b1;
                    stk_waddr = clr_reg[NODE_W-1:0];
                    stk_wdata = clr_reg[NODE_W-1:0] + NODE_W'(1);
                end
            end
            rtam_pkg::S_WALK_CHK:
            begin
                // overwrite of an existing leaf
                if (cmd_reg == rtam_pkg::CMD_INSERT && present)
                begin
                    ent_we                   = 1'b1;
                    ent_wdata[ENT_W-1]       = 1'b1;
                    ent_wdata[SIZE_BITS-1:0] = size_reg;
                end
            end
            rtam_pkg::S_INS_RD:
            begin
                cnt_raddr = node_reg;
            end
            rtam_pkg::S_INS_WR:
            begin
                ent_we             = 1'b1;
                ent_waddr          = {node_reg, key_byte};
                ent_wdata[ENT_W-1] = 1'b1;
                if (inner)
                begin
                    ent_wdata[NODE_W-1:0] = stk_rdata;
                end
                else
                begin
                    ent_wdata[SIZE_BITS-1:0] = size_reg;
                end
                cnt_we    = 1'b1;
                cnt_waddr = node_reg;
                cnt_wdata = cnt_cur + rtam_pkg::CNT_W'(1);
            end
            rtam_pkg::S_RM_RD:
            begin
                // clear the leaf on the first pass
                ent_we = (lv_reg == LV_LAST);
            end
            rtam_pkg::S_RM_DEC:
            begin
                cnt_we = 1'b1;
            end
            rtam_pkg::S_RM_UP:
            begin
                stk_we    = 1'b1;
                ent_we    = 1'b1;
                ent_waddr = {path_reg[lv_up], key_byte_up};
            end
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtam_pkg::S_CLEAR;
            clr_reg       <= '0;
            sp_reg        <= NODE_W'(NODE_POOL - 1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        size_reg     <= size_next;
        path_reg     <= path_next;
        lv_reg       <= lv_next;
        node_reg     <= node_next;
        fresh_reg    <= fresh_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        size_out_reg <= size_out_next;
    end

    // Free count never exceeds the pool less the root
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        16'(sp_reg) <= 16'(NODE_POOL - 1))
        else $error("free stack pointer out of range");

    // A full pool is never reported with found set
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rtam_pkg::STS_FULL |-> !found)
        else $error("pool full reported with found");

    // No request taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rtam_pkg::S_CLEAR |-> !in_ready)
        else $error("request accepted while clearing");

    // Lookup data only on a hit
    a_size_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> stored_size == 32'd0)
        else $error("size returned without a hit");

endmodule

`default_nettype wire
